### hdl/gnam_pkg.sv
package gnam_pkg;

  // storage defaults
  localparam int unsigned MAX_CELLS_DEF  = 65536;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // width of the linear cell address before the storage check
  localparam int unsigned ADDR_CALC_W = 26;

  // configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_COLUMNS   = 3'd0;
  localparam logic [2:0] REG_ROWS      = 3'd1;
  localparam logic [2:0] REG_LAYERS    = 3'd2;
  localparam logic [2:0] REG_BASE_VAL  = 3'd3;
  localparam logic [2:0] REG_NBR_VAL   = 3'd4;
  localparam logic [2:0] REG_USE_ALL   = 3'd5;

  // command codes
  localparam logic CMD_LOAD = 1'b0;

  // access slots of a query: the cell itself, then its six faces
  localparam logic [2:0] SLOT_CENTER   = 3'd0;
  localparam logic [2:0] SLOT_COL_DN   = 3'd1;
  localparam logic [2:0] SLOT_COL_UP   = 3'd2;
  localparam logic [2:0] SLOT_ROW_DN   = 3'd3;
  localparam logic [2:0] SLOT_ROW_UP   = 3'd4;
  localparam logic [2:0] SLOT_LAYER_DN = 3'd5;
  localparam logic [2:0] SLOT_LAYER_UP = 3'd6;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    logic [7:0]         cell_layer;
    logic signed [31:0] cell_value;
    logic               cell_active;
  } in_t;

  typedef struct packed {
    logic mark;
    logic index_error;
  } out_t;

  typedef struct packed {
    logic [8:0]         cols;
    logic [8:0]         rows;
    logic [8:0]         layers;
    logic signed [31:0] base_val;
    logic signed [31:0] nbr_val;
    logic               use_all;
    logic [17:0]        plane;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_ADDR,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } st_e;

endpackage

### hdl/gnam_ram.sv
module gnam_ram #(
  parameter int unsigned WIDTH = gnam_pkg::VALUE_BITS_DEF + 1,
  parameter int unsigned DEPTH = gnam_pkg::MAX_CELLS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/gnam_cfg.sv
module gnam_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gnam_pkg::PADDR_W-1:0] paddr,
  input  logic [gnam_pkg::PDATA_W-1:0] pwdata,
  output logic [gnam_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output gnam_pkg::cfg_t               cfg_o
);

  logic [8:0]  cols_q, rows_q, layers_q;
  logic [31:0] base_q, nbr_q;
  logic        use_all_q;
  logic [17:0] plane_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= 9'd1;
      rows_q    <= 9'd1;
      layers_q  <= 9'd1;
      base_q    <= 32'd1;
      nbr_q     <= 32'd0;
      use_all_q <= 1'b0;
      plane_q   <= 18'd1;
    end else begin
      // cells per layer, kept ready for the address calculation
      plane_q <= 18'(cols_q) * 18'(rows_q);
      if (wr_en) begin
        case (reg_idx)
          gnam_pkg::REG_COLUMNS:  cols_q    <= pwdata[8:0];
          gnam_pkg::REG_ROWS:     rows_q    <= pwdata[8:0];
          gnam_pkg::REG_LAYERS:   layers_q  <= pwdata[8:0];
          gnam_pkg::REG_BASE_VAL: base_q    <= pwdata;
          gnam_pkg::REG_NBR_VAL:  nbr_q     <= pwdata;
          gnam_pkg::REG_USE_ALL:  use_all_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      gnam_pkg::REG_COLUMNS:  prdata = 32'(cols_q);
      gnam_pkg::REG_ROWS:     prdata = 32'(rows_q);
      gnam_pkg::REG_LAYERS:   prdata = 32'(layers_q);
      gnam_pkg::REG_BASE_VAL: prdata = base_q;
      gnam_pkg::REG_NBR_VAL:  prdata = nbr_q;
      gnam_pkg::REG_USE_ALL:  prdata = 32'(use_all_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.cols     = cols_q;
  assign cfg_o.rows     = rows_q;
  assign cfg_o.layers   = layers_q;
  assign cfg_o.base_val = base_q;
  assign cfg_o.nbr_val  = nbr_q;
  assign cfg_o.use_all  = use_all_q;
  assign cfg_o.plane    = plane_q;

endmodule

### hdl/gnam_seq.sv
module gnam_seq #(
  parameter int unsigned MAX_CELLS  = gnam_pkg::MAX_CELLS_DEF,
  parameter int unsigned VALUE_BITS = gnam_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gnam_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gnam_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gnam_pkg::out_t               out_data_o,
  output logic                         ram_en_o,
  output logic                         ram_we_o,
  output logic [$clog2(MAX_CELLS)-1:0] ram_addr_o,
  output logic [VALUE_BITS:0]          ram_wdata_o,
  input  logic [VALUE_BITS:0]          ram_rdata_i
);

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned CW = gnam_pkg::ADDR_CALC_W;
  localparam logic [CW-1:0] CellLimit = CW'(MAX_CELLS);

  gnam_pkg::st_e  st_q, st_d;
  gnam_pkg::in_t  item_q, item_d;
  gnam_pkg::out_t out_data_q, out_data_d;
  logic           out_valid_q, out_valid_d;
  logic [16:0]    rowoff_q, rowoff_d;
  logic [CW-1:0]  addr_q, addr_d;
  logic           err_q, err_d;
  logic [2:0]     slot_q, slot_d;
  logic           rd_vld_q, rd_vld_d;
  logic [2:0]     rd_slot_q, rd_slot_d;
  logic           center_ok_q, center_ok_d;
  logic           hit_q, hit_d;

  // neighbour address for the current slot
  logic [CW-1:0]  nb_off, nb_addr;
  logic           nb_sub, nb_inside, nb_present;
  logic           rd_usable, rd_base_eq, rd_nbr_eq;

  always_comb begin
    nb_off    = '0;
    nb_sub    = 1'b0;
    nb_inside = 1'b1;
    case (slot_q)
      gnam_pkg::SLOT_CENTER: ;
      gnam_pkg::SLOT_COL_DN: begin
        nb_off    = CW'(1);
        nb_sub    = 1'b1;
        nb_inside = item_q.cell_col != 8'd0;
      end
      gnam_pkg::SLOT_COL_UP: begin
        nb_off    = CW'(1);
        nb_inside = (9'(item_q.cell_col) + 9'd1) < cfg_i.cols;
      end
      gnam_pkg::SLOT_ROW_DN: begin
        nb_off    = CW'(cfg_i.cols);
        nb_sub    = 1'b1;
        nb_inside = item_q.cell_row != 8'd0;
      end
      gnam_pkg::SLOT_ROW_UP: begin
        nb_off    = CW'(cfg_i.cols);
        nb_inside = (9'(item_q.cell_row) + 9'd1) < cfg_i.rows;
      end
      gnam_pkg::SLOT_LAYER_DN: begin
        nb_off    = CW'(cfg_i.plane);
        nb_sub    = 1'b1;
        nb_inside = item_q.cell_layer != 8'd0;
      end
      gnam_pkg::SLOT_LAYER_UP: begin
        nb_off    = CW'(cfg_i.plane);
        nb_inside = (9'(item_q.cell_layer) + 9'd1) < cfg_i.layers;
      end
      default: nb_inside = 1'b0;
    endcase
    nb_addr    = nb_sub ? addr_q - nb_off : addr_q + nb_off;
    nb_present = nb_inside && (nb_addr < CellLimit);
  end

  assign rd_usable  = cfg_i.use_all | ram_rdata_i[VALUE_BITS];
  assign rd_base_eq = ram_rdata_i[VALUE_BITS-1:0] == cfg_i.base_val[VALUE_BITS-1:0];
  assign rd_nbr_eq  = ram_rdata_i[VALUE_BITS-1:0] == cfg_i.nbr_val[VALUE_BITS-1:0];

  always_comb begin
    st_d        = st_q;
    item_d      = item_q;
    rowoff_d    = rowoff_q;
    addr_d      = addr_q;
    err_d       = err_q;
    slot_d      = slot_q;
    rd_vld_d    = 1'b0;
    rd_slot_d   = slot_q;
    center_ok_d = center_ok_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = nb_addr[AW-1:0];
    ram_wdata_o = {item_q.cell_active, item_q.cell_value[VALUE_BITS-1:0]};

    // read data of the slot issued last cycle
    if (rd_vld_q) begin
      if (rd_slot_q == gnam_pkg::SLOT_CENTER) begin
        center_ok_d = rd_usable & rd_base_eq;
      end else if (rd_usable & rd_nbr_eq) begin
        hit_d = 1'b1;
      end
    end

    case (st_q)
      gnam_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          st_d   = gnam_pkg::ST_ROW;
        end
      end
      gnam_pkg::ST_ROW: begin
        rowoff_d = 17'(cfg_i.cols) * 17'(item_q.cell_row);
        err_d    = (9'(item_q.cell_col) >= cfg_i.cols) ||
                   (9'(item_q.cell_row) >= cfg_i.rows) ||
                   (9'(item_q.cell_layer) >= cfg_i.layers);
        st_d     = gnam_pkg::ST_ADDR;
      end
      gnam_pkg::ST_ADDR: begin
        addr_d = CW'(cfg_i.plane) * CW'(item_q.cell_layer) + CW'(rowoff_q) +
                 CW'(item_q.cell_col);
        st_d   = gnam_pkg::ST_CHECK;
      end
      gnam_pkg::ST_CHECK: begin
        center_ok_d = 1'b0;
        hit_d       = 1'b0;
        slot_d      = gnam_pkg::SLOT_CENTER;
        if (err_q || (addr_q >= CellLimit)) begin
          err_d = 1'b1;
          st_d  = gnam_pkg::ST_DONE;
        end else if (item_q.cmd == gnam_pkg::CMD_LOAD) begin
          ram_en_o   = 1'b1;
          ram_we_o   = 1'b1;
          ram_addr_o = addr_q[AW-1:0];
          st_d       = gnam_pkg::ST_DONE;
        end else begin
          st_d = gnam_pkg::ST_READ;
        end
      end
      gnam_pkg::ST_READ: begin
        if (nb_present) begin
          ram_en_o = 1'b1;
          rd_vld_d = 1'b1;
        end
        slot_d = slot_q + 3'd1;
        if (slot_q == gnam_pkg::SLOT_LAYER_UP) begin
          st_d = gnam_pkg::ST_DRAIN;
        end
      end
      gnam_pkg::ST_DRAIN: begin
        st_d = gnam_pkg::ST_DONE;
      end
      gnam_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_data_d.mark        = center_ok_q & hit_q;
          out_data_d.index_error = err_q;
          st_d                   = gnam_pkg::ST_IDLE;
        end
      end
      default: st_d = gnam_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gnam_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    rowoff_q    <= rowoff_d;
    addr_q      <= addr_d;
    err_q       <= err_d;
    slot_q      <= slot_d;
    rd_slot_q   <= rd_slot_d;
    center_ok_q <= center_ok_d;
    hit_q       <= hit_d;
    out_data_q  <= out_data_d;
  end

  assign in_ready_o  = st_q == gnam_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/grid_neighbor_adjacency_marker.sv
// Six-connected neighbour check over a 3D grid of cell values.
// Input channel (in_valid_i/in_ready_o/in_data_i): one word per item.
//   cmd load writes value and active bit of one cell; cmd query asks
//   whether the cell holds base_value and borders a face neighbour
//   holding neighbor_value (both cells usable). Every item answers with
//   exactly one word on out_valid_o/out_ready_i/out_data_o.
// Cell address is col + columns*(row + rows*layer); cells off the grid
//   or beyond storage flag index_error and are not written.
// Steps: each item goes through ST_ROW, ST_ADDR and ST_CHECK; a load or
//   bad address then goes to ST_DONE, a query to ST_READ for the seven
//   slots, ST_DRAIN and ST_DONE. A new word is taken only after the
//   previous result is registered. The query time is set by the
//   single-port cell memory: one read per cycle for cell and six faces.
// Receiver stall: the result sits in the output register; the next item
//   is still accepted and processed, and waits at its final step until
//   the output register frees.
// Reset clears the sequencer and output valid and loads the register
//   defaults; cell memory is not cleared and must be loaded before use.
// Configuration through the APB port, only while the block is idle.
module grid_neighbor_adjacency_marker #(
  parameter int unsigned MAX_CELLS  = gnam_pkg::MAX_CELLS_DEF,
  parameter int unsigned VALUE_BITS = gnam_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gnam_pkg::PADDR_W-1:0] paddr,
  input  logic [gnam_pkg::PDATA_W-1:0] pwdata,
  output logic [gnam_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // item words in
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gnam_pkg::in_t                in_data_i,
  // result words out
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gnam_pkg::out_t               out_data_o
);

  localparam int unsigned AW = $clog2(MAX_CELLS);

  gnam_pkg::cfg_t      cfg;
  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr;
  logic [VALUE_BITS:0] ram_wdata, ram_rdata;

  gnam_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: address calculation, load write, seven-slot read sweep
  gnam_seq #(
    .MAX_CELLS  (MAX_CELLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // cell store: {active, value}
  gnam_ram #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (MAX_CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
